### hdl/cofc_pkg.sv
`default_nettype none
package cofc_pkg;

   localparam int unsigned REQ_DATA_W = 80;
   localparam int unsigned RSP_DATA_W = 120;

   // message type codes
   localparam logic [3:0] MSG_UNKNOWN   = 4'd0;
   localparam logic [3:0] MSG_NMT       = 4'd1;
   localparam logic [3:0] MSG_SYNC      = 4'd2;
   localparam logic [3:0] MSG_TIME      = 4'd3;
   localparam logic [3:0] MSG_EMCY      = 4'd4;
   localparam logic [3:0] MSG_TPDO      = 4'd5;
   localparam logic [3:0] MSG_RPDO      = 4'd6;
   localparam logic [3:0] MSG_SDO_TX    = 4'd7;
   localparam logic [3:0] MSG_SDO_RX    = 4'd8;
   localparam logic [3:0] MSG_HEARTBEAT = 4'd9;

   // function code, identifier bits 10..7
   localparam logic [3:0] FN_EMCY   = 4'h1;
   localparam logic [3:0] FN_TPDO1  = 4'h3;
   localparam logic [3:0] FN_RPDO1  = 4'h4;
   localparam logic [3:0] FN_TPDO2  = 4'h5;
   localparam logic [3:0] FN_RPDO2  = 4'h6;
   localparam logic [3:0] FN_TPDO3  = 4'h7;
   localparam logic [3:0] FN_RPDO3  = 4'h8;
   localparam logic [3:0] FN_TPDO4  = 4'h9;
   localparam logic [3:0] FN_RPDO4  = 4'hA;
   localparam logic [3:0] FN_SDO_TX = 4'hB;
   localparam logic [3:0] FN_SDO_RX = 4'hC;
   localparam logic [3:0] FN_HBEAT  = 4'hE;

   localparam logic [10:0] COB_NMT  = 11'h000;
   localparam logic [10:0] COB_SYNC = 11'h080;
   localparam logic [10:0] COB_TIME = 11'h100;

   // server command specifiers
   localparam logic [2:0] SCS_UPLOAD   = 3'd2;
   localparam logic [2:0] SCS_DOWNLOAD = 3'd3;
   localparam logic [2:0] SCS_ABORT    = 3'd4;

   localparam logic [1:0] KIND_ABORT    = 2'd0;
   localparam logic [1:0] KIND_UPLOAD   = 2'd1;
   localparam logic [1:0] KIND_DOWNLOAD = 2'd2;

   // after identifier decode
   typedef struct packed {
      logic        accepted;
      logic [3:0]  msg_type;
      logic [6:0]  node_number;
      logic [2:0]  pdo_index;
      logic        dlc8;
      logic        dlc1;
      logic [63:0] payload;
   } cls_type;

   // after command decode
   typedef struct packed {
      cls_type     cls;
      logic        detail_ok;
      logic [1:0]  sdo_kind;
      logic        sdo_expedited;
      logic [2:0]  data_len;
   } dec_type;

endpackage
`default_nettype wire

### hdl/cofc_classify.sv
`default_nettype none
module cofc_classify (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire logic [10:0]     frame_id,
   input  wire logic            is_extended,
   input  wire logic [3:0]      frame_len,
   input  wire logic [63:0]     payload,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output cofc_pkg::cls_type    out_cls
);

   logic              valid_ff;
   cofc_pkg::cls_type cls_ff;
   cofc_pkg::cls_type cls_in;
   logic [3:0]        func;
   logic [6:0]        node;

   assign func     = frame_id[10:7];
   assign node     = frame_id[6:0];
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      cls_in             = '0;
      cls_in.payload     = payload;
      cls_in.dlc8        = frame_len[3];
      cls_in.dlc1        = (frame_len != 4'd0);
      cls_in.accepted    = !is_extended;
      cls_in.node_number = node;
      priority if (is_extended) begin
         cls_in             = '0;
      end else if (frame_id == cofc_pkg::COB_NMT) begin
         cls_in.msg_type    = cofc_pkg::MSG_NMT;
         cls_in.node_number = '0;
      end else if (frame_id == cofc_pkg::COB_SYNC) begin
         cls_in.msg_type    = cofc_pkg::MSG_SYNC;
         cls_in.node_number = '0;
      end else if (frame_id == cofc_pkg::COB_TIME) begin
         cls_in.msg_type    = cofc_pkg::MSG_TIME;
         cls_in.node_number = '0;
      end else if (node != 7'd0) begin
         unique case (func)
            cofc_pkg::FN_EMCY: cls_in.msg_type = cofc_pkg::MSG_EMCY;
            cofc_pkg::FN_TPDO1: begin
               cls_in.msg_type = cofc_pkg::MSG_TPDO; cls_in.pdo_index = 3'd1;
            end
            cofc_pkg::FN_RPDO1: begin
               cls_in.msg_type = cofc_pkg::MSG_RPDO; cls_in.pdo_index = 3'd1;
            end
            cofc_pkg::FN_TPDO2: begin
               cls_in.msg_type = cofc_pkg::MSG_TPDO; cls_in.pdo_index = 3'd2;
            end
            cofc_pkg::FN_RPDO2: begin
               cls_in.msg_type = cofc_pkg::MSG_RPDO; cls_in.pdo_index = 3'd2;
            end
            cofc_pkg::FN_TPDO3: begin
               cls_in.msg_type = cofc_pkg::MSG_TPDO; cls_in.pdo_index = 3'd3;
            end
            cofc_pkg::FN_RPDO3: begin
               cls_in.msg_type = cofc_pkg::MSG_RPDO; cls_in.pdo_index = 3'd3;
            end
            cofc_pkg::FN_TPDO4: begin
               cls_in.msg_type = cofc_pkg::MSG_TPDO; cls_in.pdo_index = 3'd4;
            end
            cofc_pkg::FN_RPDO4: begin
               cls_in.msg_type = cofc_pkg::MSG_RPDO; cls_in.pdo_index = 3'd4;
            end
            cofc_pkg::FN_SDO_TX: cls_in.msg_type = cofc_pkg::MSG_SDO_TX;
            cofc_pkg::FN_SDO_RX: cls_in.msg_type = cofc_pkg::MSG_SDO_RX;
            cofc_pkg::FN_HBEAT:  cls_in.msg_type = cofc_pkg::MSG_HEARTBEAT;
            default:             cls_in.msg_type = cofc_pkg::MSG_UNKNOWN;
         endcase
      end else begin
         // node field zero on a non-broadcast id
         cls_in.msg_type = cofc_pkg::MSG_UNKNOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         cls_ff <= cls_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_cls   = cls_ff;

endmodule
`default_nettype wire

### hdl/cofc_sdo_decode.sv
`default_nettype none
module cofc_sdo_decode (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire cofc_pkg::cls_type  in_cls,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output cofc_pkg::dec_type       out_dec
);

   logic              valid_ff;
   cofc_pkg::dec_type dec_ff;
   cofc_pkg::dec_type dec_in;
   logic [7:0]        cmd;
   logic [2:0]        scs;
   logic              is_sdo;

   assign in_ready = !valid_ff || out_ready;
   assign cmd      = in_cls.payload[7:0];
   assign scs      = cmd[7:5];
   assign is_sdo   = (in_cls.msg_type == cofc_pkg::MSG_SDO_TX) && in_cls.dlc8;

   always_comb begin
      dec_in     = '0;
      dec_in.cls = in_cls;
      priority if ((in_cls.msg_type == cofc_pkg::MSG_EMCY) && in_cls.dlc8) begin
         dec_in.detail_ok = 1'b1;
      end else if ((in_cls.msg_type == cofc_pkg::MSG_HEARTBEAT) && in_cls.dlc1) begin
         dec_in.detail_ok = 1'b1;
      end else if (is_sdo && (scs == cofc_pkg::SCS_ABORT)) begin
         dec_in.detail_ok = 1'b1;
         dec_in.sdo_kind  = cofc_pkg::KIND_ABORT;
      end else if (is_sdo && (scs == cofc_pkg::SCS_UPLOAD)) begin
         dec_in.detail_ok     = 1'b1;
         dec_in.sdo_kind      = cofc_pkg::KIND_UPLOAD;
         dec_in.sdo_expedited = cmd[1];
         if (cmd[1]) begin
            // expedited: four less the unused-byte count if size is indicated, else four
            dec_in.data_len = cmd[0] ? (3'd4 - {1'b0, cmd[3:2]}) : 3'd4;
         end
      end else if (is_sdo && (scs == cofc_pkg::SCS_DOWNLOAD)) begin
         dec_in.detail_ok = 1'b1;
         dec_in.sdo_kind  = cofc_pkg::KIND_DOWNLOAD;
      end else begin
         dec_in.detail_ok = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         dec_ff <= dec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_dec   = dec_ff;

endmodule
`default_nettype wire

### hdl/cofc_assemble.sv
`default_nettype none
module cofc_assemble (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire cofc_pkg::dec_type                 in_dec,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic [cofc_pkg::RSP_DATA_W-1:0]        out_data,
   output logic [3:0]                             out_type
);

   logic                            valid_ff;
   logic [cofc_pkg::RSP_DATA_W-1:0] data_ff;
   logic [cofc_pkg::RSP_DATA_W-1:0] data_in;
   logic [3:0]                      type_ff;
   logic [15:0]                     oidx;
   logic [7:0]                      osub;
   logic [31:0]                     val;
   logic [39:0]                     extra;
   logic [31:0]                     up_data;
   logic                            is_emcy;
   logic                            is_hb;
   logic                            is_sdo;
   logic [63:0]                     p;

   assign in_ready = !valid_ff || out_ready;
   assign p        = in_dec.cls.payload;
   assign is_emcy  = in_dec.detail_ok && (in_dec.cls.msg_type == cofc_pkg::MSG_EMCY);
   assign is_hb    = in_dec.detail_ok && (in_dec.cls.msg_type == cofc_pkg::MSG_HEARTBEAT);
   assign is_sdo   = in_dec.detail_ok && (in_dec.cls.msg_type == cofc_pkg::MSG_SDO_TX);

   // expedited upload: bytes beyond data_len read as zero
   always_comb begin
      for (int b = 0; b < 4; b++) begin
         up_data[8*b +: 8] = (3'(b) < in_dec.data_len) ? p[32 + 8*b +: 8] : 8'h00;
      end
   end

   always_comb begin
      oidx  = '0;
      osub  = '0;
      val   = '0;
      extra = '0;
      priority if (is_emcy) begin
         val   = {8'h00, p[23:0]};
         extra = p[63:24];
      end else if (is_hb) begin
         val   = {25'd0, p[6:0]};
      end else if (is_sdo) begin
         oidx = p[23:8];
         osub = p[31:24];
         if (in_dec.sdo_kind == cofc_pkg::KIND_ABORT) begin
            val = p[63:32];
         end else if (in_dec.sdo_kind == cofc_pkg::KIND_UPLOAD) begin
            val = up_data;
         end
      end else begin
         val = '0;
      end
   end

   assign data_in = {6'd0, extra, in_dec.data_len, val, osub, oidx, in_dec.sdo_expedited,
                     in_dec.sdo_kind, in_dec.detail_ok, in_dec.cls.pdo_index,
                     in_dec.cls.node_number, in_dec.cls.accepted};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
         type_ff <= in_dec.cls.msg_type;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_type  = type_ff;

endmodule
`default_nettype wire

### hdl/canopen_frame_classifier.sv
// channel | dir | tdata (low bit up)                          | tuser
// req_    | in  | frame_id, frame_len, payload, zero pad      | is_extended
// rsp_    | out | accepted, node_number, pdo_index, detail_ok,| msg_type
//         |     | sdo_kind, sdo_expedited, object_index,      |
//         |     | object_sub, value_word, data_len, emcy_extra|
//
// Three register stages: identifier decode, SDO command decode, field assembly.
// One beat per cycle sustained while rsp_tready is high; each req beat passes all three in order to rsp.
// The last stage is the output register; each stage holds its beat while the
// next one is full and stalled, so back-pressure ripples upstream without loss.
// Synchronous reset empties all stages; no state beyond the pipeline.
`default_nettype none
module canopen_frame_classifier (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [cofc_pkg::REQ_DATA_W-1:0]   req_tdata,  // frame_id, frame_len, payload
   input  wire logic                              req_tuser,  // is_extended
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [cofc_pkg::RSP_DATA_W-1:0]        rsp_tdata,  // accepted .. emcy_extra
   output logic [3:0]                             rsp_tuser   // msg_type
);

   logic              s1_valid;
   logic              s1_ready;
   cofc_pkg::cls_type s1_cls;
   logic              s2_valid;
   logic              s2_ready;
   cofc_pkg::dec_type s2_dec;

   cofc_classify u_classify (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .frame_id    (req_tdata[10:0]),
      .is_extended (req_tuser),
      .frame_len   (req_tdata[14:11]),
      .payload     (req_tdata[78:15]),
      .out_valid   (s1_valid),
      .out_ready   (s1_ready),
      .out_cls     (s1_cls)
   );

   cofc_sdo_decode u_sdo_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_cls    (s1_cls),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_dec   (s2_dec)
   );

   cofc_assemble u_assemble (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_dec    (s2_dec),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_type  (rsp_tuser)
   );

endmodule
`default_nettype wire

### hdl/cofc_checker.sv
`default_nettype none
module cofc_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [cofc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire logic [3:0]                        rsp_tuser
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed under stall");

   // rejected frame carries nothing
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> (rsp_tdata == '0) && (rsp_tuser == 4'd0))
      else $error("rejected frame with non-zero fields");

   // PDO number present exactly for PDO types
   a_pdo_type: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[10:8] != 3'd0) ==
         ((rsp_tuser == cofc_pkg::MSG_TPDO) || (rsp_tuser == cofc_pkg::MSG_RPDO))))
      else $error("pdo_index inconsistent with msg_type");

   // detail decode only for EMCY, SDO server response, heartbeat
   a_detail_type: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11] |-> (rsp_tuser == cofc_pkg::MSG_EMCY) ||
         (rsp_tuser == cofc_pkg::MSG_SDO_TX) || (rsp_tuser == cofc_pkg::MSG_HEARTBEAT))
      else $error("detail_ok on undecoded type");

   // a data length only comes with an expedited upload
   a_len_exp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[73:71] != 3'd0) |-> rsp_tdata[14] && rsp_tdata[11])
      else $error("data_len without expedited upload");

endmodule

bind canopen_frame_classifier cofc_checker u_cofc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
